>>> sv/rpt_pkg.sv
// shared types, constants and helper functions of the pattern tokenizer
package rpt_pkg;

    localparam int unsigned COUNT_LIMIT  = 65535;
    localparam int unsigned OFFSET_LIMIT = 65535;

    typedef logic [255:0] t_set;

    typedef enum logic [2:0] {
        KIND_END    = 3'd0,
        KIND_OPEN   = 3'd1,
        KIND_CLOSE  = 3'd2,
        KIND_REPEAT = 3'd3,
        KIND_ALT    = 3'd4,
        KIND_SET    = 3'd5,
        KIND_FLAGS  = 3'd6,
        KIND_ERROR  = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_PARTIAL_ESC = 4'd1,
        ERR_SHORT_HEX   = 4'd2,
        ERR_BAD_HEX     = 4'd3,
        ERR_OPEN_CLASS  = 4'd4,
        ERR_BACK_RANGE  = 4'd5,
        ERR_EXTRA_COMMA = 4'd6,
        ERR_NON_DIGIT   = 4'd7,
        ERR_UNCLOSED    = 4'd8,
        ERR_ILLEGAL_CNT = 4'd9,
        ERR_ZERO_CNT    = 4'd10,
        ERR_BACKWARDS   = 4'd11,
        ERR_BACKREF     = 4'd12,
        ERR_OVERFLOW    = 4'd13
    } t_err;

    typedef struct packed {
        logic [7:0] pattern_byte;
        logic       is_end;
    } t_in;

    typedef struct packed {
        t_kind       token_kind;
        t_set        set_bits;
        logic [15:0] repeat_min;
        logic [15:0] repeat_max;
        logic        max_unbounded;
        logic        ignore_case;
        t_err        error_code;
        logic [15:0] position;
    } t_tok;

    // bits lo..hi set
    function automatic t_set span_mask(input logic [7:0] lo, input logic [7:0] hi);
        t_set m;
        m = '0;
        for (int c = 0; c < 256; c++) begin
            m[c] = (8'(c) >= lo) && (8'(c) <= hi);
        end
        return m;
    endfunction

    function automatic t_set one_hot(input logic [7:0] c);
        t_set m;
        m = '0;
        m[c] = 1'b1;
        return m;
    endfunction

    // set of one item, escaped classes expanded
    function automatic t_set class_set(input logic [7:0] ch, input logic esc);
        t_set d;
        t_set s;
        t_set w;
        d = span_mask(8'h30, 8'h39);
        s = span_mask(8'd9, 8'd13) | one_hot(8'h20);
        w = d | span_mask(8'h41, 8'h5a) | span_mask(8'h61, 8'h7a) | one_hot(8'h5f);
        if (!esc) begin
            return one_hot(ch);
        end
        unique case (ch)
            8'h44:   return ~d;
            8'h64:   return d;
            8'h53:   return ~s;
            8'h73:   return s;
            8'h57:   return ~w;
            8'h77:   return w;
            default: return one_hot(ch);
        endcase
    endfunction

    function automatic logic [4:0] hex_val(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
        return 5'd0;
    endfunction

endpackage

>>> sv/rpt_if.sv
// valid/ready channel interfaces of the pattern tokenizer
interface rpt_in_if;
    logic        valid;
    logic        ready;
    rpt_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rpt_out_if;
    logic         valid;
    logic         ready;
    rpt_pkg::t_tok data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/regex_pattern_tokenizer.sv
// top level of the regular-expression pattern tokenizer
// One pattern beat is taken per cycle while the token register is free, and each beat gives at most one token.
// The input register holds the beat; the parse step updates the state and loads the
// token register once that register is free; the input stays ready whenever the token
// register is empty or being drained, so a steady stream runs at one beat a cycle.
module regex_pattern_tokenizer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpt_in_if.sink    i_in,
    rpt_out_if.source o_out
);

    typedef enum logic [2:0] {
        M_TOP, M_CLS_FIRST, M_CLS_NEEDX, M_CLS_HAVEX, M_CLS_DASH, M_BRACE
    } t_mode;
    typedef enum logic [1:0] { E_NONE, E_AFTER, E_HEX1, E_HEX2 } t_esc;

    logic          r_in_vld;
    rpt_pkg::t_in  r_in;
    logic          r_out_vld;
    rpt_pkg::t_tok r_out;

    t_mode         r_mode, n_mode;
    t_esc          r_esc, n_esc;
    rpt_pkg::t_set r_cls, n_cls;
    logic [7:0]    r_pch, n_pch;
    logic          r_pesc, n_pesc;
    logic [7:0]    r_rs, n_rs;
    logic [3:0]    r_hex, n_hex;
    logic          r_inv, n_inv;
    logic [16:0]   r_c1, n_c1;
    logic [16:0]   r_c2, n_c2;
    logic          r_dig, n_dig;
    logic          r_com, n_com;
    logic [15:0]   r_off, n_off;

    logic          emit;
    rpt_pkg::t_tok tok;
    logic          step;
    logic          out_free;

    assign out_free = !r_out_vld || o_out.ready;
    assign step     = r_in_vld && out_free;
    assign i_in.ready = !r_in_vld || out_free;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    always_comb begin
        logic [7:0]    b;
        logic [7:0]    ch;
        logic          esc;
        logic          have_item;
        logic          is_err;
        rpt_pkg::t_err err;
        logic [4:0]    hv;
        logic [20:0]   v;
        logic          plain_close;
        logic          clear;
        logic          fin;
        rpt_pkg::t_set cb;
        b = r_in.pattern_byte;
        ch = b;
        esc = 1'b0;
        have_item = 1'b0;
        is_err = 1'b0;
        err = rpt_pkg::ERR_NONE;
        clear = 1'b0;
        fin = 1'b0;
        hv = rpt_pkg::hex_val(b);
        v = 21'(r_c2) * 21'd10 + 21'(b - 8'h30);
        plain_close = 1'b0;
        cb = r_cls;
        n_mode = r_mode; n_esc = r_esc; n_cls = r_cls; n_pch = r_pch; n_pesc = r_pesc;
        n_rs = r_rs; n_hex = r_hex; n_inv = r_inv; n_c1 = r_c1; n_c2 = r_c2;
        n_dig = r_dig; n_com = r_com; n_off = r_off;
        emit = 1'b0;
        tok = '0;
        if (r_in.is_end) begin
            emit = 1'b1;
            tok.position = r_off;
            priority if (r_esc == E_AFTER) begin
                is_err = 1'b1; err = rpt_pkg::ERR_PARTIAL_ESC;
            end else if (r_esc != E_NONE) begin
                is_err = 1'b1; err = rpt_pkg::ERR_SHORT_HEX;
            end else if (r_mode == M_BRACE) begin
                is_err = 1'b1; err = rpt_pkg::ERR_UNCLOSED;
            end else if (r_mode != M_TOP) begin
                is_err = 1'b1; err = rpt_pkg::ERR_OPEN_CLASS;
            end else begin
                tok.token_kind = rpt_pkg::KIND_END;
                clear = 1'b1;
                n_off = '0;
            end
        end else begin
            if (r_off != 16'(rpt_pkg::OFFSET_LIMIT)) n_off = r_off + 16'd1;
            tok.position = n_off;
            if (r_mode == M_BRACE) begin
                priority if (b == 8'h7d) begin
                    priority if (!r_com && r_c2 == '0) begin
                        is_err = 1'b1; err = rpt_pkg::ERR_ILLEGAL_CNT;
                    end else if (r_com && r_dig && r_c1 == '0 && r_c2 == '0) begin
                        is_err = 1'b1; err = rpt_pkg::ERR_ZERO_CNT;
                    end else if (r_dig && r_com && r_c2 < r_c1) begin
                        is_err = 1'b1; err = rpt_pkg::ERR_BACKWARDS;
                    end else begin
                        emit = 1'b1;
                        tok.token_kind = rpt_pkg::KIND_REPEAT;
                        tok.repeat_min = r_com ? r_c1[15:0] : r_c2[15:0];
                        tok.repeat_max = r_dig ? r_c2[15:0] : 16'd0;
                        tok.max_unbounded = !r_dig;
                        clear = 1'b1;
                    end
                end else if (b == 8'h2c) begin
                    if (r_com) begin
                        is_err = 1'b1; err = rpt_pkg::ERR_EXTRA_COMMA;
                    end else begin
                        n_c1 = r_c2; n_c2 = '0; n_dig = 1'b0; n_com = 1'b1;
                    end
                end else if (b >= 8'h30 && b <= 8'h39) begin
                    if (v > 21'(rpt_pkg::COUNT_LIMIT)) begin
                        is_err = 1'b1; err = rpt_pkg::ERR_OVERFLOW;
                    end else begin
                        n_c2 = v[16:0]; n_dig = 1'b1;
                    end
                end else begin
                    is_err = 1'b1; err = rpt_pkg::ERR_NON_DIGIT;
                end
            end else begin
                unique case (r_esc)
                    E_AFTER: begin
                        n_esc = E_NONE;
                        have_item = 1'b1;
                        unique case (b)
                            8'h30: ch = 8'd0;
                            8'h61: ch = 8'd7;
                            8'h62: ch = 8'd8;
                            8'h6e: ch = 8'd10;
                            8'h72: ch = 8'd13;
                            8'h74: ch = 8'd9;
                            8'h76: ch = 8'd11;
                            8'h5c: ch = 8'h5c;
                            8'h78: begin have_item = 1'b0; n_esc = E_HEX1; end
                            default: esc = 1'b1;
                        endcase
                    end
                    E_HEX1: begin
                        if (!hv[4]) begin
                            is_err = 1'b1; err = rpt_pkg::ERR_BAD_HEX;
                        end else begin
                            n_hex = hv[3:0]; n_esc = E_HEX2;
                        end
                    end
                    E_HEX2: begin
                        if (!hv[4]) begin
                            is_err = 1'b1; err = rpt_pkg::ERR_BAD_HEX;
                        end else begin
                            n_esc = E_NONE; have_item = 1'b1; ch = {r_hex, hv[3:0]};
                        end
                    end
                    default: begin
                        priority if (b == 8'h5c) begin
                            n_esc = E_AFTER;
                        end else if (r_mode == M_TOP && b == 8'h28) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_OPEN;
                        end else if (r_mode == M_TOP && b == 8'h29) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_CLOSE;
                        end else if (r_mode == M_TOP && b == 8'h2a) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_REPEAT;
                            tok.max_unbounded = 1'b1;
                        end else if (r_mode == M_TOP && b == 8'h2b) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_REPEAT;
                            tok.max_unbounded = 1'b1; tok.repeat_min = 16'd1;
                        end else if (r_mode == M_TOP && b == 8'h3f) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_REPEAT;
                            tok.repeat_max = 16'd1;
                        end else if (r_mode == M_TOP && b == 8'h7c) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_ALT;
                        end else if (r_mode == M_TOP && b == 8'h2e) begin
                            emit = 1'b1; tok.token_kind = rpt_pkg::KIND_SET;
                            tok.set_bits = '1;
                        end else if (r_mode == M_TOP && b == 8'h5b) begin
                            clear = 1'b1;
                        end else if (r_mode == M_TOP && b == 8'h7b) begin
                            clear = 1'b1;
                        end else begin
                            have_item = 1'b1;
                        end
                    end
                endcase
                plain_close = !esc && ch == 8'h5d;
                if (have_item) begin
                    unique case (r_mode)
                        M_TOP: begin
                            emit = 1'b1;
                            priority if (esc && ch >= 8'h31 && ch <= 8'h39) begin
                                is_err = 1'b1; err = rpt_pkg::ERR_BACKREF;
                            end else if (esc && ch == 8'h69) begin
                                tok.token_kind = rpt_pkg::KIND_FLAGS;
                                tok.ignore_case = 1'b1;
                            end else begin
                                tok.token_kind = rpt_pkg::KIND_SET;
                                tok.set_bits = rpt_pkg::class_set(ch, esc);
                            end
                        end
                        M_CLS_FIRST: begin
                            priority if (!esc && ch == 8'h5e && !r_inv) begin
                                n_inv = 1'b1;
                            end else if (!esc && (ch == 8'h2d || ch == 8'h5d)) begin
                                n_cls = r_cls | rpt_pkg::one_hot(ch);
                                n_mode = M_CLS_NEEDX;
                            end else begin
                                n_pch = ch; n_pesc = esc; n_mode = M_CLS_HAVEX;
                            end
                        end
                        M_CLS_NEEDX: begin
                            if (plain_close) begin
                                fin = 1'b1;
                            end else begin
                                n_pch = ch; n_pesc = esc; n_mode = M_CLS_HAVEX;
                            end
                        end
                        M_CLS_HAVEX: begin
                            if (!esc && ch == 8'h2d) begin
                                n_rs = r_pch; n_mode = M_CLS_DASH;
                            end else begin
                                cb = r_cls | rpt_pkg::class_set(r_pch, r_pesc);
                                n_cls = cb;
                                if (plain_close) begin
                                    fin = 1'b1;
                                end else begin
                                    n_pch = ch; n_pesc = esc; n_mode = M_CLS_HAVEX;
                                end
                            end
                        end
                        M_CLS_DASH: begin
                            priority if (plain_close) begin
                                cb = r_cls | rpt_pkg::one_hot(r_rs) | rpt_pkg::one_hot(8'h2d);
                                fin = 1'b1;
                            end else if (r_rs > ch) begin
                                is_err = 1'b1; err = rpt_pkg::ERR_BACK_RANGE;
                            end else begin
                                n_cls = r_cls | rpt_pkg::span_mask(r_rs, ch);
                                n_mode = M_CLS_NEEDX;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
        if (fin) begin
            emit = 1'b1;
            tok.token_kind = rpt_pkg::KIND_SET;
            tok.set_bits = r_inv ? ~cb : cb;
            clear = 1'b1;
        end
        if (is_err) begin
            emit = 1'b1;
            tok = '0;
            tok.token_kind = rpt_pkg::KIND_ERROR;
            tok.error_code = err;
            tok.position = r_in.is_end ? r_off : n_off;
            clear = 1'b1;
            n_off = '0;
        end
        if (clear) begin
            n_mode = M_TOP; n_esc = E_NONE; n_cls = '0; n_pch = '0; n_pesc = 1'b0;
            n_rs = '0; n_hex = '0; n_inv = 1'b0; n_c1 = '0; n_c2 = '0;
            n_dig = 1'b0; n_com = 1'b0;
            if (!is_err && !r_in.is_end && b == 8'h5b && r_mode == M_TOP && !emit)
                n_mode = M_CLS_FIRST;
            if (!is_err && !r_in.is_end && b == 8'h7b && r_mode == M_TOP && !emit)
                n_mode = M_BRACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode <= M_TOP; r_esc <= E_NONE; r_cls <= '0; r_pch <= '0; r_pesc <= 1'b0;
            r_rs <= '0; r_hex <= '0; r_inv <= 1'b0; r_c1 <= '0; r_c2 <= '0;
            r_dig <= 1'b0; r_com <= 1'b0; r_off <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
                r_in <= i_in.data;
            end
            if (out_free) begin
                r_out_vld <= step && emit;
            end
            if (step) begin
                if (emit) r_out <= tok;
                r_mode <= n_mode; r_esc <= n_esc; r_cls <= n_cls; r_pch <= n_pch;
                r_pesc <= n_pesc; r_rs <= n_rs; r_hex <= n_hex; r_inv <= n_inv;
                r_c1 <= n_c1; r_c2 <= n_c2; r_dig <= n_dig; r_com <= n_com;
                r_off <= n_off;
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |=> r_out_vld && $stable(r_out))
        else $error("token lost under stall");
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out.token_kind == rpt_pkg::KIND_ERROR) ==
                       (r_out.error_code != rpt_pkg::ERR_NONE)))
        else $error("error code mismatch");
    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit && tok.token_kind == rpt_pkg::KIND_ERROR |=>
            r_mode == M_TOP && r_off == '0)
        else $error("not idle after error");

endmodule
